// ----- design/ptc_pkg.sv -----
// shared types, codes and constants for the pressure/temperature compensation block
// no dependencies
package ptc_pkg;

    localparam int PIPE_DEPTH = 78;
    localparam int DIV_STAGES = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_AC12 = 3'd0;
    localparam logic [2:0] REG_AC34 = 3'd1;
    localparam logic [2:0] REG_AC56 = 3'd2;
    localparam logic [2:0] REG_B12  = 3'd3;
    localparam logic [2:0] REG_MCMD = 3'd4;
    localparam logic [2:0] REG_OSS  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic [31:0]        B4_BIAS    = 32'd32768;
    localparam logic [15:0]        P_FACTOR   = 16'd50000;
    localparam logic signed [31:0] C_3038     = 32'sd3038;
    localparam logic signed [31:0] C_M7357    = -32'sd7357;
    localparam logic signed [31:0] C_3791     = 32'sd3791;
    localparam logic signed [31:0] T_MAX      = 32'sd32767;
    localparam logic signed [31:0] T_MIN      = -32'sd32768;
    localparam logic signed [31:0] P_MAX      = 32'sd262143;

    // sideband that rides along the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               zt;
    } ptc_tside_t;

    // sideband that rides along the pressure divider
    typedef struct packed {
        logic [15:0] temp;
        logic        tsat;
        logic        zt;
        logic        zp;
        logic        big;
    } ptc_pside_t;

endpackage

// ----- design/ptc_div.sv -----
// pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage
// depends on ptc_pkg
module ptc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);
    import ptc_pkg::*;

    logic [31:0] a_reg [DIV_STAGES];
    logic [31:0] r_reg [DIV_STAGES];
    logic [31:0] d_reg [DIV_STAGES];
    logic [31:0] a_next [DIV_STAGES];
    logic [31:0] r_next [DIV_STAGES];

    always_comb
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            logic [31:0] a_in;
            logic [31:0] r_in;
            logic [31:0] d_in;
            logic [32:0] trial;
            a_in  = (i == 0) ? num : a_reg[(i == 0) ? 0 : i - 1];
            r_in  = (i == 0) ? 32'd0 : r_reg[(i == 0) ? 0 : i - 1];
            d_in  = (i == 0) ? den : d_reg[(i == 0) ? 0 : i - 1];
            trial = {r_in, a_in[31]};
            if (trial >= {1'b0, d_in})
            begin
                r_next[i] = 32'(trial - {1'b0, d_in});
                a_next[i] = {a_in[30:0], 1'b1};
            end
            else
            begin
                r_next[i] = trial[31:0];
                a_next[i] = {a_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                a_reg[i] <= a_next[i];
                r_reg[i] <= r_next[i];
                d_reg[i] <= (i == 0) ? den : d_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign quo = a_reg[DIV_STAGES - 1];

endmodule

// ----- design/pressure_temperature_compensation.sv -----
// top level of the barometric pressure/temperature compensation pipeline
// depends on ptc_pkg and ptc_div
//
// takes one beat of raw temperature and raw pressure per cycle and returns one
// beat of compensated temperature (0.1 degC), pressure (Pa) and status, as long
// as the output side does not stall. the pipeline is 78 register stages deep;
// two 32-stage restoring dividers (temperature and pressure) make up most of
// those stages. throughput is one beat every cycle while results are taken.
// the whole pipe advances together: while a finished result is not taken, the
// pipe holds and in_ready is low. calibration and oversampling are read live
// by the stages that use them, so write them only while no beat
// is in flight. a zero divisor gives zero fields with the zero-divisor status;
// out of range values clamp with the saturation status.
module pressure_temperature_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] raw_temperature,
    input  logic [18:0] raw_pressure,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] temperature_tenths,
    output logic [17:0] pressure_pa,
    output logic [1:0]  status
);
    import ptc_pkg::*;

    // calibration registers
    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AC12: ac12_reg <= cfg_wdata;
                REG_AC34: ac34_reg <= cfg_wdata;
                REG_AC56: ac56_reg <= cfg_wdata;
                REG_B12:  b12_reg  <= cfg_wdata;
                REG_MCMD: mcmd_reg <= cfg_wdata;
                REG_OSS:  oss_reg  <= cfg_wdata[1:0];
                default:  ;
            endcase
        end
    end

    // calibration fields: ac1-ac3, b1, b2, mc and md sign-extended to 32 bits, ac4-ac6 unsigned 16 bits
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;
    assign ac1 = 32'($signed(ac12_reg[31:16]));
    assign ac2 = 32'($signed(ac12_reg[15:0]));
    assign ac3 = 32'($signed(ac34_reg[31:16]));
    assign ac4 = ac34_reg[15:0];
    assign ac5 = ac56_reg[31:16];
    assign ac6 = ac56_reg[15:0];
    assign b1  = 32'($signed(b12_reg[31:16]));
    assign b2  = 32'($signed(b12_reg[15:0]));
    assign mc  = 32'($signed(mcmd_reg[31:16]));
    assign md  = 32'($signed(mcmd_reg[15:0]));

    // global advance: the pipe moves unless a finished result is stalled
    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign en       = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
    end

    // stage a: (ut - ac6) * ac5
    logic [31:0] a_prod_reg;
    logic [18:0] a_up_reg;
    logic signed [17:0] a_diff;
    logic signed [34:0] a_prod;
    assign a_diff = $signed({2'b00, raw_temperature}) - $signed({2'b00, ac6});
    assign a_prod = a_diff * $signed({1'b0, ac5});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod[31:0];
            a_up_reg   <= raw_pressure;
        end
    end

    // stage b: x1, divisor x1 + md, magnitudes for the temperature divider
    logic signed [31:0] b_x1, b_div, b_tnum;
    logic [31:0] b_num_reg, b_den_reg;
    ptc_tside_t b_side_reg;
    assign b_x1   = $signed(a_prod_reg) >>> 15;
    assign b_div  = b_x1 + md;
    assign b_tnum = mc <<< 11;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_num_reg      <= b_tnum[31] ? 32'(-b_tnum) : b_tnum;
            b_den_reg      <= b_div[31] ? 32'(-b_div) : b_div;
            b_side_reg.x1  <= b_x1;
            b_side_reg.up  <= a_up_reg;
            b_side_reg.neg <= b_tnum[31] ^ b_div[31];
            b_side_reg.zt  <= (b_div == 32'sd0);
        end
    end

    // temperature divider with its sideband delay line
    logic [31:0] t_quo;
    ptc_tside_t  t_side_reg [DIV_STAGES];

    ptc_div u_tdiv (
        .clk (clk),
        .en  (en),
        .num (b_num_reg),
        .den (b_den_reg),
        .quo (t_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_side_reg[0] <= b_side_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                t_side_reg[i] <= t_side_reg[i-1];
        end
    end

    // stage c: b5 = x1 + signed quotient
    logic signed [31:0] c_b5_reg;
    logic [18:0] c_up_reg;
    logic        c_zt_reg;
    ptc_tside_t  c_in;
    assign c_in = t_side_reg[DIV_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_b5_reg <= c_in.x1 + (c_in.neg ? $signed(32'(-t_quo)) : $signed(t_quo));
            c_up_reg <= c_in.up;
            c_zt_reg <= c_in.zt;
        end
    end

    // stage d: temperature with clamp, b6
    logic signed [31:0] d_tt;
    logic signed [31:0] d_b6_reg;
    logic [15:0] d_temp_reg;
    logic        d_tsat_reg, d_zt_reg;
    logic [18:0] d_up_reg;
    assign d_tt = (c_b5_reg + 32'sd8) >>> 4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_tt > T_MAX)
                d_temp_reg <= T_MAX[15:0];
            else if (d_tt < T_MIN)
                d_temp_reg <= T_MIN[15:0];
            else
                d_temp_reg <= d_tt[15:0];
            d_tsat_reg <= (d_tt > T_MAX) || (d_tt < T_MIN);
            d_b6_reg   <= c_b5_reg - B6_OFFSET;
            d_up_reg   <= c_up_reg;
            d_zt_reg   <= c_zt_reg;
        end
    end

    // stage e: b6 squared, ac2 * b6, ac3 * b6
    logic signed [31:0] e_sq_reg, e_ac2_reg, e_ac3_reg;
    logic [15:0] e_temp_reg;
    logic        e_tsat_reg, e_zt_reg;
    logic [18:0] e_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sq_reg   <= d_b6_reg * d_b6_reg;
            e_ac2_reg  <= ac2 * d_b6_reg;
            e_ac3_reg  <= ac3 * d_b6_reg;
            e_temp_reg <= d_temp_reg;
            e_tsat_reg <= d_tsat_reg;
            e_up_reg   <= d_up_reg;
            e_zt_reg   <= d_zt_reg;
        end
    end

    // stage f: scale the products
    logic signed [31:0] f_sq_reg, f_x2a_reg, f_x1c_reg;
    logic [15:0] f_temp_reg;
    logic        f_tsat_reg, f_zt_reg;
    logic [18:0] f_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sq_reg   <= e_sq_reg >>> 12;
            f_x2a_reg  <= e_ac2_reg >>> 11;
            f_x1c_reg  <= e_ac3_reg >>> 13;
            f_temp_reg <= e_temp_reg;
            f_tsat_reg <= e_tsat_reg;
            f_up_reg   <= e_up_reg;
            f_zt_reg   <= e_zt_reg;
        end
    end

    // stage g: b2 * sq, b1 * sq
    logic signed [31:0] g_b2_reg, g_b1_reg, g_x2a_reg, g_x1c_reg;
    logic [15:0] g_temp_reg;
    logic        g_tsat_reg, g_zt_reg;
    logic [18:0] g_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_b2_reg   <= b2 * f_sq_reg;
            g_b1_reg   <= b1 * f_sq_reg;
            g_x2a_reg  <= f_x2a_reg;
            g_x1c_reg  <= f_x1c_reg;
            g_temp_reg <= f_temp_reg;
            g_tsat_reg <= f_tsat_reg;
            g_up_reg   <= f_up_reg;
            g_zt_reg   <= f_zt_reg;
        end
    end

    // stage h: b3 and the x3 term of b4
    logic signed [31:0] h_x3, h_sh, h_b3_reg, h_x3b_reg;
    logic [15:0] h_temp_reg;
    logic        h_tsat_reg, h_zt_reg;
    logic [18:0] h_up_reg;
    assign h_x3 = (g_b2_reg >>> 11) + g_x2a_reg;
    assign h_sh = (ac1 <<< 2) + h_x3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_b3_reg   <= ((h_sh <<< oss_reg) + 32'sd2) >>> 2;
            h_x3b_reg  <= (g_x1c_reg + (g_b1_reg >>> 16) + 32'sd2) >>> 2;
            h_temp_reg <= g_temp_reg;
            h_tsat_reg <= g_tsat_reg;
            h_up_reg   <= g_up_reg;
            h_zt_reg   <= g_zt_reg;
        end
    end

    // stage i: b4 product and b7
    logic [31:0] i_b4p_reg, i_b7_reg;
    logic [15:0] i_temp_reg;
    logic        i_tsat_reg, i_zt_reg;
    logic [15:0] i_fac;
    assign i_fac = P_FACTOR >> oss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_b4p_reg  <= 32'({16'd0, ac4} * (h_x3b_reg + B4_BIAS));
            i_b7_reg   <= 32'(({13'd0, h_up_reg} - h_b3_reg) * {16'd0, i_fac});
            i_temp_reg <= h_temp_reg;
            i_tsat_reg <= h_tsat_reg;
            i_zt_reg   <= h_zt_reg;
        end
    end

    // stage j: operands for the pressure divider
    logic [31:0] j_b4;
    logic [31:0] j_num_reg, j_den_reg;
    ptc_pside_t  j_side_reg;
    assign j_b4 = i_b4p_reg >> 15;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_num_reg       <= i_b7_reg[31] ? i_b7_reg : {i_b7_reg[30:0], 1'b0};
            j_den_reg       <= j_b4;
            j_side_reg.temp <= i_temp_reg;
            j_side_reg.tsat <= i_tsat_reg;
            j_side_reg.zt   <= i_zt_reg;
            j_side_reg.zp   <= (j_b4 == 32'd0);
            j_side_reg.big  <= i_b7_reg[31];
        end
    end

    // pressure divider with its sideband delay line
    logic [31:0] p_quo;
    ptc_pside_t  p_side_reg [DIV_STAGES];

    ptc_div u_pdiv (
        .clk (clk),
        .en  (en),
        .num (j_num_reg),
        .den (j_den_reg),
        .quo (p_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg[0] <= j_side_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                p_side_reg[i] <= p_side_reg[i-1];
        end
    end

    // stage k: p and p >> 8
    logic signed [31:0] k_p_reg, k_px_reg;
    logic [31:0] k_pu;
    ptc_pside_t  k_side_reg, k_in;
    assign k_in = p_side_reg[DIV_STAGES-1];
    assign k_pu = k_in.big ? {p_quo[30:0], 1'b0} : p_quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_p_reg    <= $signed(k_pu);
            k_px_reg   <= $signed(k_pu) >>> 8;
            k_side_reg <= k_in;
        end
    end

    // stage l: (p >> 8) squared and -7357 * p
    logic signed [31:0] l_xx_reg, l_m7_reg, l_p_reg;
    ptc_pside_t  l_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_xx_reg   <= k_px_reg * k_px_reg;
            l_m7_reg   <= C_M7357 * k_p_reg;
            l_p_reg    <= k_p_reg;
            l_side_reg <= k_side_reg;
        end
    end

    // stage m: times 3038, and -7357 * p shifted down by 16
    logic signed [31:0] m_m3_reg, m_x2_reg, m_p_reg;
    ptc_pside_t  m_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_m3_reg   <= l_xx_reg * C_3038;
            m_x2_reg   <= l_m7_reg >>> 16;
            m_p_reg    <= l_p_reg;
            m_side_reg <= l_side_reg;
        end
    end

    // stage n: final pressure, clamps and status into the output register
    logic signed [31:0] n_pp;
    logic               n_psat;
    logic signed [15:0] temp_reg;
    logic [17:0]        pres_reg;
    logic [1:0]         status_reg;
    assign n_pp   = m_p_reg + (((m_m3_reg >>> 16) + m_x2_reg + C_3791) >>> 4);
    assign n_psat = (n_pp < 32'sd0) || (n_pp > P_MAX);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (m_side_reg.zt || m_side_reg.zp)
            begin
                temp_reg   <= '0;
                pres_reg   <= '0;
                status_reg <= ST_ZDIV;
            end
            else
            begin
                temp_reg <= $signed(m_side_reg.temp);
                if (n_pp < 32'sd0)
                    pres_reg <= '0;
                else if (n_pp > P_MAX)
                    pres_reg <= P_MAX[17:0];
                else
                    pres_reg <= n_pp[17:0];
                status_reg <= (m_side_reg.tsat || n_psat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign temperature_tenths = temp_reg;
    assign pressure_pa        = pres_reg;
    assign status             = status_reg;

`ifndef SYNTHESIS
    // a zero-divisor result carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ZDIV) |-> (temperature_tenths == 16'sd0 && pressure_pa == 18'd0))
        else $error("zero divisor result with nonzero fields");

    // status never carries the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_ZDIV || status == ST_SAT))
        else $error("undefined status code");

    // a stalled pipe keeps all of its valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg))
        else $error("pipe moved during a stall");

    // a pressure with ok status stays within the clamp bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (pressure_pa <= P_MAX[17:0]))
        else $error("pressure out of range with ok status");
`endif

endmodule

// ----- verif/tb_pressure_temperature_compensation.sv -----
// self-checking testbench for the pressure/temperature compensation pipeline
// depends on ptc_pkg and the pressure_temperature_compensation rtl
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    // one compensated reading as the block returns it
    typedef struct {
        logic signed [15:0] temp;
        logic [17:0]        pres;
        logic [1:0]         stat;
    } reading_t;

    // one raw sensor beat waiting to go in
    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
    } raw_t;

    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
    logic        out_valid;
    logic        out_ready;
    logic signed [15:0] temperature_tenths;
    logic [17:0] pressure_pa;
    logic [1:0]  status;

    // calibration copy used for prediction
    logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
    logic [1:0]  cal_oss;

    raw_t     raw_queue[$];
    reading_t expected_readings[$];

    int  errors;
    int  readings_checked;
    int  zdiv_seen, sat_seen;
    int  quiet_cycles;
    int  in_gap, out_stall;
    int  out_draw;
    logic in_took, out_took;
    logic no_gap_mode;

    pressure_temperature_compensation dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .raw_temperature    (raw_temperature),
        .raw_pressure       (raw_pressure),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .temperature_tenths (temperature_tenths),
        .pressure_pa        (pressure_pa),
        .status             (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // compensation predictor: all intermediates wrap at 32 bits
    function automatic reading_t compensate(input logic [15:0] ut_raw,
                                            input logic [18:0] up_raw);
        reading_t    r;
        int          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
        int unsigned ac4, b4, b7, pu, x3u, upu, b3u;
        int          ut, x1, x2, x3, dv, b5, t, b6, sq, b3, p;
        ac1 = $signed(cal_ac12[31:16]);
        ac2 = $signed(cal_ac12[15:0]);
        ac3 = $signed(cal_ac34[31:16]);
        ac4 = {16'd0, cal_ac34[15:0]};
        ac5 = {16'd0, cal_ac56[31:16]};
        ac6 = {16'd0, cal_ac56[15:0]};
        b1  = $signed(cal_b12[31:16]);
        b2  = $signed(cal_b12[15:0]);
        mc  = $signed(cal_mcmd[31:16]);
        md  = $signed(cal_mcmd[15:0]);
        ut  = {16'd0, ut_raw};
        upu = {13'd0, up_raw};
        r.temp = '0;
        r.pres = '0;
        r.stat = ST_ZDIV;

        // temperature path
        x1 = ((ut - ac6) * ac5) >>> 15;
        dv = x1 + md;
        if (dv == 0)
            return r;
        x2 = (mc * 2048) / dv;
        b5 = x1 + x2;
        t  = (b5 + 8) >>> 4;
        r.stat = ST_OK;
        if (t > 32767)
        begin
            t = 32767;
            r.stat = ST_SAT;
        end
        if (t < -32768)
        begin
            t = -32768;
            r.stat = ST_SAT;
        end

        // b3 and b4
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) << cal_oss) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        x3u = x3;
        b4 = (ac4 * (x3u + 32'd32768)) >> 15;
        if (b4 == 0)
        begin
            r.stat = ST_ZDIV;
            return r;
        end

        // pressure path
        b3u = b3;
        b7 = (upu - b3u) * (32'd50000 >> cal_oss);
        if (b7 < 32'h8000_0000)
            pu = (b7 << 1) / b4;
        else
            pu = (b7 / b4) << 1;
        p  = pu;
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p  = p + ((x1 + x2 + 3791) >>> 4);
        if (p < 0)
        begin
            p = 0;
            r.stat = ST_SAT;
        end
        if (p > 262143)
        begin
            p = 262143;
            r.stat = ST_SAT;
        end
        r.temp = t[15:0];
        r.pres = p[17:0];
        return r;
    endfunction

    // input driver: loads the next raw beat after a random gap, or with no gap in no-gap mode
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else if (in_valid && !in_took)
        begin
            // hold the beat until it is taken
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (raw_queue.size() > 0)
        begin
            raw_temperature <= raw_queue[0].ut;
            raw_pressure    <= raw_queue[0].up;
            void'(raw_queue.pop_front());
            in_valid <= 1'b1;
            in_gap   <= no_gap_mode ? 0 : $urandom_range(0, 6);
        end
        else
            in_valid <= 1'b0;
    end

    // output side back-pressure, a fresh stall drawn per result beat (none in no-gap mode)
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_took)
        begin
            out_draw   = no_gap_mode ? 0 : $urandom_range(0, 6);
            out_ready <= (out_draw == 0);
            out_stall <= (out_draw > 0) ? out_draw - 1 : 0;
        end
        else if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge clk)
    begin
        reading_t want;
        if (!rst_n)
        begin
            in_took      <= 1'b0;
            out_took     <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_took  <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
            if (in_valid && in_ready)
                expected_readings.push_back(compensate(raw_temperature, raw_pressure));
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat temp=%0d pres=%0d status=%0d",
                             $time, temperature_tenths, pressure_pa, status);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    if (want.stat == ST_ZDIV)
                        zdiv_seen++;
                    if (want.stat == ST_SAT)
                        sat_seen++;
                    if (temperature_tenths !== want.temp)
                    begin
                        errors++;
                        $display("%0t: temperature_tenths expected %0d actual %0d",
                                 $time, want.temp, temperature_tenths);
                    end
                    if (pressure_pa !== want.pres)
                    begin
                        errors++;
                        $display("%0t: pressure_pa expected %0d actual %0d",
                                 $time, want.pres, pressure_pa);
                    end
                    if (status !== want.stat)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, status);
                    end
                end
            end

            // watchdog only runs while work is outstanding
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (in_valid || raw_queue.size() > 0 || expected_readings.size() > 0)
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // one register write on the configuration port
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // load a full calibration set and keep the predictor copy in step
    task automatic load_calibration(input logic [31:0] w_ac12, input logic [31:0] w_ac34,
                                    input logic [31:0] w_ac56, input logic [31:0] w_b12,
                                    input logic [31:0] w_mcmd, input logic [31:0] w_oss);
        write_reg(REG_AC12, w_ac12);
        write_reg(REG_AC34, w_ac34);
        write_reg(REG_AC56, w_ac56);
        write_reg(REG_B12,  w_b12);
        write_reg(REG_MCMD, w_mcmd);
        write_reg(REG_OSS,  w_oss);
        cal_ac12 = w_ac12;
        cal_ac34 = w_ac34;
        cal_ac56 = w_ac56;
        cal_b12  = w_b12;
        cal_mcmd = w_mcmd;
        cal_oss  = w_oss[1:0];
    endtask

    // wait until every beat is in and every result is out, then let the pipe settle
    task automatic drain_pipe;
        while (raw_queue.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic push_raw(input logic [15:0] ut, input logic [18:0] up);
        raw_t b;
        b.ut = ut;
        b.up = up;
        raw_queue.push_back(b);
    endtask

    // random beats: mostly near a realistic operating point, some full range
    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                push_raw(16'($urandom_range(20000, 36000)),
                         19'($urandom_range(15000, 30000) << cal_oss));
            else
                push_raw(16'($urandom), 19'($urandom));
        end
    endtask

    // datasheet style calibration words
    localparam logic [31:0] TYP_AC12 = {16'sd408, -16'sd72};
    localparam logic [31:0] TYP_AC34 = {-16'sd14383, 16'd32741};
    localparam logic [31:0] TYP_AC56 = {16'd32757, 16'd23153};
    localparam logic [31:0] TYP_B12  = {16'sd6190, 16'sd4};
    localparam logic [31:0] TYP_MCMD = {-16'sd8711, 16'sd2868};

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        out_ready       = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        errors          = 0;
        readings_checked = 0;
        zdiv_seen       = 0;
        sat_seen        = 0;
        out_draw        = 0;
        no_gap_mode     = 1'b0;
        cal_ac12 = '0; cal_ac34 = '0; cal_ac56 = '0;
        cal_b12  = '0; cal_mcmd = '0; cal_oss  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset calibration is all zero: every beat hits the zero divisor
        push_raw(16'd27898, 19'd23843);
        push_raw(16'hFFFF, 19'h7FFFF);
        drain_pipe();

        // directed beats on the typical calibration, every oversampling value
        for (int o = 0; o < 4; o++)
        begin
            load_calibration(TYP_AC12, TYP_AC34, TYP_AC56, TYP_B12, TYP_MCMD, o);
            push_raw(16'd27898, 19'd23843 << o);
            push_raw(16'd0, 19'd0);
            push_raw(16'hFFFF, 19'h7FFFF);
            push_raw(16'd0, 19'h7FFFF);
            push_raw(16'hFFFF, 19'd0);
            drain_pipe();
        end

        // x1 + md lands on zero: md is zero and x1 is zero with ut equal to ac6
        load_calibration(TYP_AC12, TYP_AC34, TYP_AC56, TYP_B12, {-16'sd8711, 16'sd0}, 0);
        push_raw(16'd23153, 19'd23843);
        push_raw(16'd23154, 19'd23843);
        drain_pipe();

        // ac4 of zero forces b4 to zero
        load_calibration(TYP_AC12, {-16'sd14383, 16'd0}, TYP_AC56, TYP_B12, TYP_MCMD, 0);
        push_raw(16'd27898, 19'd23843);
        drain_pipe();

        // all ones in every register
        load_calibration('1, '1, '1, '1, '1, 32'd3);
        push_raw(16'd0, 19'd0);
        push_raw(16'hFFFF, 19'h7FFFF);
        push_random(40);
        drain_pipe();

        // random phases: typical calibration, perturbed, and fully random words
        for (int ph = 0; ph < 12; ph++)
        begin
            no_gap_mode = (ph % 4 == 3);
            case (ph % 3)
                0: load_calibration(TYP_AC12, TYP_AC34, TYP_AC56, TYP_B12, TYP_MCMD,
                                    $urandom_range(0, 3));
                1: load_calibration(TYP_AC12 ^ ($urandom & 32'h00FF_00FF),
                                    TYP_AC34 ^ ($urandom & 32'h00FF_00FF),
                                    TYP_AC56 ^ ($urandom & 32'h00FF_00FF),
                                    TYP_B12  ^ ($urandom & 32'h00FF_00FF),
                                    TYP_MCMD ^ ($urandom & 32'h00FF_00FF),
                                    $urandom_range(0, 3));
                default: load_calibration($urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom);
            endcase
            push_random(125);
            drain_pipe();
        end
        no_gap_mode = 1'b0;

        // back to the reset-like extreme
        load_calibration('0, '0, '0, '0, '0, 32'd0);
        push_random(10);
        drain_pipe();

        $display("checked %0d compensated readings over 21 calibration settings",
                 readings_checked);
        $display("zero divisor results %0d, saturated results %0d", zdiv_seen, sat_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ptc_pkg.sv
design/ptc_div.sv
design/pressure_temperature_compensation.sv
verif/tb_pressure_temperature_compensation.sv
